/* hw/rtl/trace_window_crc_signature_macros.svh */
// Assertion macros shared by the trace window CRC signature block.
`ifndef TRACE_WINDOW_CRC_SIGNATURE_MACROS_SVH
`define TRACE_WINDOW_CRC_SIGNATURE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TWCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TWCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/twcs_pkg.sv */
// Types, constants and the CRC fold function of the trace window signature block.
package twcs_pkg;

    localparam logic [31:0] DIGEST_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam int unsigned MASK_W      = 31;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [4:0]  IDX_NONE    = 5'd31;

    typedef enum logic [1:0] {
        FUNC_ADDR  = 2'd0,
        FUNC_ENTER = 2'd1,
        FUNC_EXIT  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        VRD_UNDECIDED = 2'd0,
        VRD_MATCH     = 2'd1,
        VRD_MISMATCH  = 2'd2
    } verdict_t;

    typedef struct packed {
        func_t       func;
        logic [4:0]  routine_index;
        logic [63:0] instr_address;
    } trace_item_t;

    typedef struct packed {
        logic [31:0] digest_now;
        logic        window_open;
        logic [15:0] windows_closed;
        verdict_t    verdict;
    } result_item_t;

    // Continued reflected CRC-32 over eight address bytes, low byte first.
    // Bit-serial form of the byte loop; flattens into one XOR tree.
    function automatic logic [31:0] crc_fold(input logic [31:0] digest,
                                             input logic [63:0] addr);
        logic [31:0] r;
        r = digest ^ DIGEST_INIT;
        for (int i = 0; i < 64; i++)
        begin
            r = (r[0] ^ addr[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r ^ DIGEST_INIT;
    endfunction

endpackage

/* hw/rtl/twcs_trace_if.sv */
// Trace event channel: valid/ready handshake with the event payload.
interface twcs_trace_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [4:0]  routine_index;
    logic [63:0] instr_address;

    modport source (output valid, output func, output routine_index,
                    output instr_address, input ready);
    modport sink   (input valid, input func, input routine_index,
                    input instr_address, output ready);
endinterface

/* hw/rtl/twcs_result_if.sv */
// Result channel: valid/ready handshake with the signature status payload.
interface twcs_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_now;
    logic        window_open;
    logic [15:0] windows_closed;
    logic [1:0]  verdict;

    modport source (output valid, output digest_now, output window_open,
                    output windows_closed, output verdict, input ready);
    modport sink   (input valid, input digest_now, input window_open,
                    input windows_closed, input verdict, output ready);
endinterface

/* hw/rtl/twcs_core.sv */
// Signature state: routine mask, window flag, running digest, reference and verdict.
module twcs_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [4:0]              cfg_wdata,
    input  logic                    step,
    input  twcs_pkg::trace_item_t   item,
    output twcs_pkg::result_item_t  result_next
);

    logic [4:0]                    routines_reg;
    logic [twcs_pkg::MASK_W-1:0]   mask_reg;
    logic [twcs_pkg::MASK_W-1:0]   mask_next;
    logic                          open_reg;
    logic                          open_next;
    logic [31:0]                   digest_reg;
    logic [31:0]                   digest_next;
    logic [31:0]                   first_reg;
    logic [31:0]                   first_next;
    logic [15:0]                   count_reg;
    logic [15:0]                   count_next;
    logic                          mismatch_reg;
    logic                          mismatch_next;
    logic [twcs_pkg::MASK_W-1:0]   ref_mask;
    logic [twcs_pkg::MASK_W-1:0]   bit_sel;
    logic [twcs_pkg::MASK_W-1:0]   mask_set;
    logic [twcs_pkg::MASK_W-1:0]   mask_clr;
    logic [31:0]                   ref_wide;

    assign ref_wide = (32'd1 << routines_reg) - 32'd1;
    assign ref_mask = ref_wide[twcs_pkg::MASK_W-1:0];
    assign bit_sel  = (item.routine_index == twcs_pkg::IDX_NONE) ? '0
                    : (twcs_pkg::MASK_W'(1) << item.routine_index);
    assign mask_set = mask_reg | bit_sel;
    assign mask_clr = mask_reg & ~bit_sel;

    always_comb
    begin
        mask_next     = mask_reg;
        open_next     = open_reg;
        digest_next   = digest_reg;
        first_next    = first_reg;
        count_next    = count_reg;
        mismatch_next = mismatch_reg;
        case (item.func)
            twcs_pkg::FUNC_ADDR:
            begin
                if (open_reg)
                begin
                    digest_next = twcs_pkg::crc_fold(digest_reg, item.instr_address);
                end
            end
            twcs_pkg::FUNC_ENTER:
            begin
                if (bit_sel != '0)
                begin
                    // open on the transfer that completes the reference mask
                    if (mask_set == ref_mask && mask_reg != ref_mask)
                    begin
                        open_next   = 1'b1;
                        digest_next = twcs_pkg::DIGEST_INIT;
                    end
                    mask_next = mask_set;
                end
            end
            twcs_pkg::FUNC_EXIT:
            begin
                if (bit_sel != '0)
                begin
                    if (mask_clr != ref_mask && mask_reg == ref_mask)
                    begin
                        open_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            first_next = digest_reg;
                        end
                        else if (digest_reg != first_reg)
                        begin
                            mismatch_next = 1'b1;
                        end
                        if (count_reg != twcs_pkg::COUNT_MAX)
                        begin
                            count_next = count_reg + 16'd1;
                        end
                    end
                    mask_next = mask_clr;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result_next.digest_now     = digest_next;
        result_next.window_open    = open_next;
        result_next.windows_closed = count_next;
        if (count_next < 16'd2)
        begin
            result_next.verdict = twcs_pkg::VRD_UNDECIDED;
        end
        else if (mismatch_next)
        begin
            result_next.verdict = twcs_pkg::VRD_MISMATCH;
        end
        else
        begin
            result_next.verdict = twcs_pkg::VRD_MATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            routines_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            routines_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            open_reg     <= 1'b0;
            digest_reg   <= twcs_pkg::DIGEST_INIT;
            count_reg    <= '0;
            mismatch_reg <= 1'b0;
        end
        else if (step)
        begin
            mask_reg     <= mask_next;
            open_reg     <= open_next;
            digest_reg   <= digest_next;
            count_reg    <= count_next;
            mismatch_reg <= mismatch_next;
        end
    end

    // reference digest holds no reset; it is read only after the first close
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            first_reg <= first_next;
        end
    end

endmodule

/* hw/rtl/trace_window_crc_signature.sv */
// Top level of the trace window CRC signature monitor.
//
//   channel   role     payload
//   trace     sink     func, routine_index, instr_address
//   result    source   digest_now, window_open, windows_closed, verdict
//   cfg       write    cfg_we, cfg_wdata (routines_in_use)
//
// One item per cycle sustained while the result channel is not stalled; a result
// leaves through the input register, then the 64-bit CRC XOR tree and state update
// into the result register. A stalled result holds the output register; the input
// register still takes a transfer in any cycle in which its item can move on.
// rst_n clears the routine mask, window flag, count and fail flag, sets the digest
// to all ones and routines_in_use to one.
`include "trace_window_crc_signature_macros.svh"

module trace_window_crc_signature
(
    input  logic                 clk,
    input  logic                 rst_n,
    twcs_trace_if.sink           trace,
    twcs_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata
);

    logic                    in_valid_reg;
    twcs_pkg::trace_item_t   in_item_reg;
    logic                    out_valid_reg;
    twcs_pkg::result_item_t  result_reg;
    twcs_pkg::result_item_t  result_next;
    logic                    advance;

    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign trace.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (trace.ready)
        begin
            in_valid_reg <= trace.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (trace.valid && trace.ready)
        begin
            in_item_reg.func          <= twcs_pkg::func_t'(trace.func);
            in_item_reg.routine_index <= trace.routine_index;
            in_item_reg.instr_address <= trace.instr_address;
        end
    end

    twcs_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .step        (advance),
        .item        (in_item_reg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.digest_now     = result_reg.digest_now;
    assign result.window_open    = result_reg.window_open;
    assign result.windows_closed = result_reg.windows_closed;
    assign result.verdict        = result_reg.verdict;

    `TWCS_ASSERT_NEXT(a_item_kept, clk, rst_n, in_valid_reg && !advance, in_valid_reg, "input item dropped while blocked")
    `TWCS_ASSERT_NOW(a_ready_when_free, clk, rst_n, !out_valid_reg, trace.ready, "input stalled with free output register")
    `TWCS_ASSERT_NOW(a_verdict_count, clk, rst_n, out_valid_reg && result_reg.verdict != twcs_pkg::VRD_UNDECIDED, result_reg.windows_closed >= 16'd2, "verdict given before two closed windows")

endmodule
